// ----- rtl/core/lbm_d2q9_moments_equilibrium_assert.svh -----
// Assertion macros shared by the lattice Boltzmann equilibrium RTL.
// No dependencies; the including module supplies clock and reset names.
`ifndef LBM_D2Q9_MOMENTS_EQUILIBRIUM_ASSERT_SVH
`define LBM_D2Q9_MOMENTS_EQUILIBRIUM_ASSERT_SVH

// Condition c must hold in the same cycle as a.
`define LBM_ASSERT_SAME(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("lbm assertion failed");

// Condition c must hold in the cycle after a.
`define LBM_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("lbm assertion failed");

`endif

// ----- rtl/core/lbm_pkg.sv -----
// Constants and direction tables for the D2Q9 moments and equilibrium block.
// No dependencies.
package lbm_pkg;
   localparam int FRAC_BITS_DEF = 15;
   localparam int NDIR = 9;
   // Direction order: sw, s, se, w, c, e, nw, n, ne.
   localparam int DIR_CX [NDIR] = '{-1, 0, 1, -1, 0, 1, -1, 0, 1};
   localparam int DIR_CY [NDIR] = '{-1, -1, -1, 0, 0, 0, 1, 1, 1};
   // Weight numerators 1, 4 and 16 over 36, as left shifts.
   localparam int DIR_WSH [NDIR] = '{0, 2, 0, 2, 4, 2, 0, 2, 0};
   localparam logic [19:0] RECIP9 = 20'd932068;
   localparam int RECIP9_SH = 23;
   localparam logic [19:0] CLAMP_LIM = 20'd589824;
   localparam logic [15:0] EQ_MAX = 16'hFFFF;
endpackage

// ----- rtl/core/lbm_d2q9_moments_equilibrium.sv -----
// D2Q9 lattice Boltzmann moments and equilibrium, fully pipelined.
// Depends on lbm_pkg and lbm_d2q9_moments_equilibrium_assert.svh.
//
//   Channel   Direction   Ports
//   req       in          req_valid, req_stall, req_dist_sw .. req_dist_ne
//   rsp       out         rsp_valid, rsp_stall, rsp_density, rsp_vel_*, rsp_eq_*
//
// One item enters per cycle while no result is stalled; the two restoring
// dividers resolve one velocity bit per stage.
// Synchronous reset clears only the valid bits of the stages.
// A stalled result holds the whole pipeline; req_stall follows it.
`include "lbm_d2q9_moments_equilibrium_assert.svh"
module lbm_d2q9_moments_equilibrium #(
   parameter int FRAC_BITS = lbm_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_dist_sw,
   input  logic [15:0]        req_dist_s,
   input  logic [15:0]        req_dist_se,
   input  logic [15:0]        req_dist_w,
   input  logic [15:0]        req_dist_c,
   input  logic [15:0]        req_dist_e,
   input  logic [15:0]        req_dist_nw,
   input  logic [15:0]        req_dist_n,
   input  logic [15:0]        req_dist_ne,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [19:0]        rsp_density,
   output logic signed [15:0] rsp_vel_x,
   output logic signed [15:0] rsp_vel_y,
   output logic [15:0]        rsp_eq_sw,
   output logic [15:0]        rsp_eq_s,
   output logic [15:0]        rsp_eq_se,
   output logic [15:0]        rsp_eq_w,
   output logic [15:0]        rsp_eq_c,
   output logic [15:0]        rsp_eq_e,
   output logic [15:0]        rsp_eq_nw,
   output logic [15:0]        rsp_eq_n,
   output logic [15:0]        rsp_eq_ne
);
   localparam int F = FRAC_BITS;
   localparam int ND = lbm_pkg::NDIR;
   localparam int DIV_ST = F + 1;
   localparam int NST = F + 9;
   localparam int E1 = F + 2;
   localparam int QW = (F + 1 > 17) ? F + 1 : 17;
   localparam int M1 = (2 * F + 1 > F + 19) ? 2 * F + 1 : F + 19;
   localparam int M2 = (M1 > 36) ? M1 : 36;
   localparam int WN = M2 + 3;
   localparam int PW = WN - F - 1;
   localparam int XA = 20 + PW;
   localparam int XB = XA + 4;
   localparam logic signed [WN-1:0] TWO_S2 = WN'(1) << (2 * F + 1);

   logic adv;
   logic [NST-1:0] v_ff;
   logic [NST-1:0] v_in;

   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign v_in = {v_ff[NST-2:0], req_valid};
   assign rsp_valid = v_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   // Input stage: density and momentum magnitudes.
   logic [19:0] s0_rho_ff, s0_magx_ff, s0_magy_ff;
   logic        s0_negx_ff, s0_negy_ff;
   logic [19:0] rho_in;
   logic [17:0] px, nx, py, ny;

   always_comb begin
      rho_in = 20'(req_dist_sw) + 20'(req_dist_s) + 20'(req_dist_se) + 20'(req_dist_w)
             + 20'(req_dist_c) + 20'(req_dist_e) + 20'(req_dist_nw) + 20'(req_dist_n)
             + 20'(req_dist_ne);
      px = 18'(req_dist_e) + 18'(req_dist_ne) + 18'(req_dist_se);
      nx = 18'(req_dist_w) + 18'(req_dist_nw) + 18'(req_dist_sw);
      py = 18'(req_dist_n) + 18'(req_dist_ne) + 18'(req_dist_nw);
      ny = 18'(req_dist_s) + 18'(req_dist_se) + 18'(req_dist_sw);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_rho_ff  <= rho_in;
         s0_negx_ff <= nx > px;
         s0_negy_ff <= ny > py;
         s0_magx_ff <= (nx > px) ? 20'(nx - px) : 20'(px - nx);
         s0_magy_ff <= (ny > py) ? 20'(ny - py) : 20'(py - ny);
      end
   end

   // Restoring dividers, one quotient bit per stage.
   logic [19:0] dv_remx_ff [DIV_ST];
   logic [19:0] dv_remy_ff [DIV_ST];
   logic [F:0]  dv_qx_ff [DIV_ST];
   logic [F:0]  dv_qy_ff [DIV_ST];
   logic [19:0] dv_rho_ff [DIV_ST];
   logic        dv_nx_ff [DIV_ST];
   logic        dv_ny_ff [DIV_ST];

   genvar j;
   for (j = 0; j < DIV_ST; j++) begin : g_div
      logic [20:0] tx, ty;
      logic [19:0] rp;
      logic [F:0]  qxp, qyp;
      logic        nxp, nyp, bx, by;
      if (j == 0) begin : g_first
         assign tx  = {1'b0, s0_magx_ff};
         assign ty  = {1'b0, s0_magy_ff};
         assign rp  = s0_rho_ff;
         assign qxp = '0;
         assign qyp = '0;
         assign nxp = s0_negx_ff;
         assign nyp = s0_negy_ff;
      end else begin : g_next
         assign tx  = {dv_remx_ff[j-1], 1'b0};
         assign ty  = {dv_remy_ff[j-1], 1'b0};
         assign rp  = dv_rho_ff[j-1];
         assign qxp = dv_qx_ff[j-1];
         assign qyp = dv_qy_ff[j-1];
         assign nxp = dv_nx_ff[j-1];
         assign nyp = dv_ny_ff[j-1];
      end
      assign bx = tx >= {1'b0, rp};
      assign by = ty >= {1'b0, rp};
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_remx_ff[j] <= bx ? 20'(tx - {1'b0, rp}) : tx[19:0];
            dv_remy_ff[j] <= by ? 20'(ty - {1'b0, rp}) : ty[19:0];
            dv_qx_ff[j]   <= {qxp[F-1:0], bx};
            dv_qy_ff[j]   <= {qyp[F-1:0], by};
            dv_rho_ff[j]  <= rp;
            dv_nx_ff[j]   <= nxp;
            dv_ny_ff[j]   <= nyp;
         end
      end
   end

   // E1: saturated velocity.
   logic [19:0]        e1_rho_ff;
   logic               e1_zero_ff;
   logic signed [15:0] e1_ux_ff, e1_uy_ff;
   logic [QW-1:0]      qxe, qye;
   logic signed [15:0] ux_in, uy_in;
   logic               zero_in;

   always_comb begin
      qxe = QW'(dv_qx_ff[DIV_ST-1]);
      qye = QW'(dv_qy_ff[DIV_ST-1]);
      zero_in = dv_rho_ff[DIV_ST-1] == 20'd0;
      if (dv_nx_ff[DIV_ST-1]) begin
         ux_in = (qxe > QW'(32768)) ? 16'sh8000 : 16'(-qxe);
      end else begin
         ux_in = (qxe > QW'(32767)) ? 16'sh7FFF : 16'(qxe);
      end
      if (dv_ny_ff[DIV_ST-1]) begin
         uy_in = (qye > QW'(32768)) ? 16'sh8000 : 16'(-qye);
      end else begin
         uy_in = (qye > QW'(32767)) ? 16'sh7FFF : 16'(qye);
      end
      if (zero_in) begin
         ux_in = '0;
         uy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e1_rho_ff  <= dv_rho_ff[DIV_ST-1];
         e1_zero_ff <= zero_in;
         e1_ux_ff   <= ux_in;
         e1_uy_ff   <= uy_in;
      end
   end

   // E2 to E7 pass-through and per-direction registers.
   logic [19:0]        e2_rho_ff, e3_rho_ff, e4_rho_ff, e5_rho_ff, e6_rho_ff;
   logic               e2_zero_ff, e3_zero_ff, e4_zero_ff, e5_zero_ff, e6_zero_ff;
   logic signed [15:0] e2_ux_ff, e3_ux_ff, e4_ux_ff, e5_ux_ff, e6_ux_ff;
   logic signed [15:0] e2_uy_ff, e3_uy_ff, e4_uy_ff, e5_uy_ff, e6_uy_ff;
   logic [30:0]        e2_ux2_ff, e2_uy2_ff;
   logic [31:0]        e3_usq_ff;
   logic signed [31:0] sqx, sqy;
   logic signed [17:0] e2_cu_ff [ND];
   logic [32:0]        e3_cu2_ff [ND];
   logic signed [WN-1:0] e3_lin_ff [ND];
   logic [PW-1:0]      e4_p_ff [ND];
   logic [XA-1:0]      e5_x_ff [ND];
   logic [39:0]        e6_prod_ff [ND];
   logic               e6_clamp_ff [ND];
   logic [15:0]        e7_eq_ff [ND];
   logic [19:0]        e7_rho_ff;
   logic signed [15:0] e7_ux_ff, e7_uy_ff;

   assign sqx = e1_ux_ff * e1_ux_ff;
   assign sqy = e1_uy_ff * e1_uy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         e2_rho_ff <= e1_rho_ff;  e2_zero_ff <= e1_zero_ff;
         e2_ux_ff  <= e1_ux_ff;   e2_uy_ff   <= e1_uy_ff;
         e2_ux2_ff <= sqx[30:0];  e2_uy2_ff  <= sqy[30:0];
         e3_rho_ff <= e2_rho_ff;  e3_zero_ff <= e2_zero_ff;
         e3_ux_ff  <= e2_ux_ff;   e3_uy_ff   <= e2_uy_ff;
         e3_usq_ff <= 32'(e2_ux2_ff) + 32'(e2_uy2_ff);
         e4_rho_ff <= e3_rho_ff;  e4_zero_ff <= e3_zero_ff;
         e4_ux_ff  <= e3_ux_ff;   e4_uy_ff   <= e3_uy_ff;
         e5_rho_ff <= e4_rho_ff;  e5_zero_ff <= e4_zero_ff;
         e5_ux_ff  <= e4_ux_ff;   e5_uy_ff   <= e4_uy_ff;
         e6_rho_ff <= e5_rho_ff;  e6_zero_ff <= e5_zero_ff;
         e6_ux_ff  <= e5_ux_ff;   e6_uy_ff   <= e5_uy_ff;
         e7_rho_ff <= e6_rho_ff;
         e7_ux_ff  <= e6_ux_ff;   e7_uy_ff   <= e6_uy_ff;
      end
   end

   genvar i;
   for (i = 0; i < ND; i++) begin : g_dir
      logic signed [17:0]   ax, ay, cu_in;
      logic signed [35:0]   c2;
      logic signed [WN-1:0] cuw, c2w, uw, n_in, lin_in;
      logic [XB-1:0]        y_in;
      always_comb begin
         ax = (lbm_pkg::DIR_CX[i] == 1) ? 18'(e1_ux_ff)
            : (lbm_pkg::DIR_CX[i] == -1) ? -18'(e1_ux_ff) : 18'sd0;
         ay = (lbm_pkg::DIR_CY[i] == 1) ? 18'(e1_uy_ff)
            : (lbm_pkg::DIR_CY[i] == -1) ? -18'(e1_uy_ff) : 18'sd0;
         cu_in = ax + ay;
         c2 = e2_cu_ff[i] * e2_cu_ff[i];
         cuw = WN'(e2_cu_ff[i]);
         lin_in = TWO_S2 + (cuw <<< (F + 2)) + (cuw <<< (F + 1));
         c2w = WN'(e3_cu2_ff[i]);
         uw = WN'(e3_usq_ff);
         n_in = e3_lin_ff[i] + (c2w <<< 3) + c2w - (uw <<< 1) - uw;
         y_in = (XB'(e5_x_ff[i]) << lbm_pkg::DIR_WSH[i]) >> (F + 2);
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            e2_cu_ff[i]    <= cu_in;
            e3_cu2_ff[i]   <= c2[32:0];
            e3_lin_ff[i]   <= lin_in;
            e4_p_ff[i]     <= (n_in > 0) ? n_in[WN-1:F+1] : '0;
            e5_x_ff[i]     <= XA'(e4_rho_ff) * XA'(e4_p_ff[i]);
            e6_clamp_ff[i] <= y_in >= XB'(lbm_pkg::CLAMP_LIM);
            e6_prod_ff[i]  <= 40'(y_in[19:0]) * 40'(lbm_pkg::RECIP9);
            e7_eq_ff[i]    <= e6_zero_ff ? 16'd0
                            : e6_clamp_ff[i] ? lbm_pkg::EQ_MAX
                            : e6_prod_ff[i][lbm_pkg::RECIP9_SH+15:lbm_pkg::RECIP9_SH];
         end
      end
   end

   assign rsp_density = e7_rho_ff;
   assign rsp_vel_x   = e7_ux_ff;
   assign rsp_vel_y   = e7_uy_ff;
   assign rsp_eq_sw   = e7_eq_ff[0];
   assign rsp_eq_s    = e7_eq_ff[1];
   assign rsp_eq_se   = e7_eq_ff[2];
   assign rsp_eq_w    = e7_eq_ff[3];
   assign rsp_eq_c    = e7_eq_ff[4];
   assign rsp_eq_e    = e7_eq_ff[5];
   assign rsp_eq_nw   = e7_eq_ff[6];
   assign rsp_eq_n    = e7_eq_ff[7];
   assign rsp_eq_ne   = e7_eq_ff[8];

   `LBM_ASSERT_SAME(a_stall_source, clock, reset, req_stall, rsp_valid && rsp_stall)
   `LBM_ASSERT_SAME(a_zero_vel, clock, reset, rsp_valid && rsp_density == 20'd0,
      rsp_vel_x == 16'sd0 && rsp_vel_y == 16'sd0)
   `LBM_ASSERT_SAME(a_zero_eq, clock, reset, rsp_valid && rsp_density == 20'd0,
      rsp_eq_c == 16'd0 && rsp_eq_ne == 16'd0)
   `LBM_ASSERT_NEXT(a_hold_valid, clock, reset, v_ff[E1] && req_stall, v_ff[E1])
endmodule
